[rtl/assert_macros.svh]
// Assertion macros used by the slot core of the frame buffer slot rotator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define FBSR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("fbsr assertion failed");
// Condition must never be true at a clock edge outside reset.
`define FBSR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("fbsr forbidden condition seen");
`else
`define FBSR_ASSERT(lbl, clk, rst_n, prop)
`define FBSR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[rtl/fbsr_pkg.sv]
// Types, constants and helper functions for the frame buffer slot rotator.
package fbsr_pkg;

	localparam int BUFFER_COUNT = 4;
	localparam int BUF_IDX_W    = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 28;

	typedef logic [BUF_IDX_W-1:0] idx_t;

	localparam idx_t RST_FIRST_SLOT  = idx_t'(0 % BUFFER_COUNT);
	localparam idx_t RST_SECOND_SLOT = idx_t'(1 % BUFFER_COUNT);
	localparam idx_t RST_NEXT_FREE   = idx_t'(2 % BUFFER_COUNT);
	localparam idx_t RST_LATEST      = idx_t'(3 % BUFFER_COUNT);

	localparam logic [11:0] RST_HRES   = 12'd0;
	localparam logic [11:0] RST_VRES   = 12'd0;
	localparam logic [27:0] RST_BASE   = 28'h0200000;
	localparam logic [23:0] RST_STRIDE = 24'd4147200;
	localparam logic [31:0] LEN_MASK   = 32'h0fffffff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HRES   = 2'd0,
		REG_VRES   = 2'd1,
		REG_BASE   = 2'd2,
		REG_STRIDE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [11:0] horizontal_res;
		logic [11:0] vertical_res;
		logic [27:0] region_base;
		logic [23:0] buffer_stride;
	} cfg_t;

	typedef struct packed {
		logic        first_pending;
		logic [31:0] first_dma_address;
		logic        second_pending;
		logic [31:0] second_dma_address;
	} in_t;

	typedef struct packed {
		logic        first_reload;
		logic [31:0] first_new_address;
		logic        first_stray;
		logic        second_reload;
		logic [31:0] second_new_address;
		logic        second_stray;
		logic        frame_done;
		logic [1:0]  shown_index;
	} out_t;

	// Base address of a ring buffer, modulo 2^32.
	function automatic logic [31:0] buf_base(input idx_t idx, input cfg_t cfg);
		logic [31:0] off;
		off = 32'(cfg.buffer_stride) * 32'(idx);
		return 32'(cfg.region_base) + off;
	endfunction

	// Ring advance with wrap at the buffer count.
	function automatic idx_t ring_next(input idx_t idx);
		logic [BUF_IDX_W:0] inc;
		inc = {1'b0, idx} + {{BUF_IDX_W{1'b0}}, 1'b1};
		return (inc >= (BUF_IDX_W+1)'(BUFFER_COUNT)) ? '0 : inc[BUF_IDX_W-1:0];
	endfunction

endpackage

[rtl/frame_buffer_slot_rotator.sv]
// Top level of the frame buffer slot rotator: request and result registers.
//
// Each request is one DMA completion event for two capture slots and yields
// exactly one result. A request is taken into an input register, evaluated by
// short logic (expected length hres*vres*2, region bounds check with an
// inclusive upper bound, slot 0 then slot 1 length check and ring rotation
// over the buffer ring) and written to a result register together with the
// update of the slot ownership state. Throughput is one request per clock
// while out_stall is low. The ownership state is updated in the same cycle
// the request moves into the result register, so consecutive requests chain
// without bubbles. A stalled result register stalls the input register, and
// that in turn raises in_stall; in_stall depends combinationally on
// out_stall. There is no clearing pass after reset. Configuration is written
// through a plain write port; the user must write it only while no request
// is in flight, which the block does not enforce. Index 0 horizontal
// resolution, 1 vertical resolution, 2 region base, 3 buffer stride.
module frame_buffer_slot_rotator (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  fbsr_pkg::in_t                   in_data,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output fbsr_pkg::out_t                  out_data,
	// configuration write port
	input  logic                            cfg_wr_en,
	input  logic [fbsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbsr_pkg::CFG_DATA_W-1:0] cfg_data
);

	fbsr_pkg::cfg_t cfg;
	fbsr_pkg::in_t  req_s1;
	fbsr_pkg::out_t res_comb, res_s2;
	logic           valid_s1, valid_s2;
	logic           load_s2, advance, load_s1;

	// result register takes a new value when empty or being drained
	assign load_s2  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && load_s2;
	// input register may take a request when empty or moving on
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	fbsr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fbsr_slot_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.cfg     (cfg),
		.res     (res_comb)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s2 || !valid_s1) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

[rtl/fbsr_cfg_regs.sv]
// Configuration register file of the frame buffer slot rotator.
module fbsr_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [fbsr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fbsr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output fbsr_pkg::cfg_t                     cfg
);

	fbsr_pkg::cfg_t    cfg_q;
	fbsr_pkg::cfg_idx_t widx;

	assign widx = fbsr_pkg::cfg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.horizontal_res <= fbsr_pkg::RST_HRES;
			cfg_q.vertical_res   <= fbsr_pkg::RST_VRES;
			cfg_q.region_base    <= fbsr_pkg::RST_BASE;
			cfg_q.buffer_stride  <= fbsr_pkg::RST_STRIDE;
		end else if (cfg_wr_en) begin
			unique case (widx)
				fbsr_pkg::REG_HRES:   cfg_q.horizontal_res <= cfg_data[11:0];
				fbsr_pkg::REG_VRES:   cfg_q.vertical_res   <= cfg_data[11:0];
				fbsr_pkg::REG_BASE:   cfg_q.region_base    <= cfg_data[27:0];
				fbsr_pkg::REG_STRIDE: cfg_q.buffer_stride  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/fbsr_slot_core.sv]
// Slot ownership state and per-event slot evaluation.
`include "assert_macros.svh"

module fbsr_slot_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  fbsr_pkg::in_t    req,
	input  fbsr_pkg::cfg_t   cfg,
	output fbsr_pkg::out_t   res
);

	fbsr_pkg::idx_t first_q, second_q, next_free_q, latest_q;
	fbsr_pkg::idx_t first_d, second_d, next_mid, next_free_d, latest_mid, latest_d;

	logic [23:0] hv_prod;
	logic [31:0] expected;
	logic [31:0] lo_bound, hi_bound;
	logic [31:0] len0, len1;
	logic        hit0, hit1;

	assign hv_prod  = 24'(cfg.horizontal_res) * 24'(cfg.vertical_res);
	assign expected = {7'd0, hv_prod, 1'b0};
	assign lo_bound = 32'(cfg.region_base);
	assign hi_bound = lo_bound + 32'(cfg.buffer_stride) * 32'(fbsr_pkg::BUFFER_COUNT);

	always_comb begin
		// slot 0 first
		len0       = req.first_dma_address
			- (fbsr_pkg::buf_base(first_q, cfg) & fbsr_pkg::LEN_MASK);
		hit0       = req.first_pending && (len0 == expected);
		first_d    = hit0 ? next_free_q : first_q;
		next_mid   = hit0 ? fbsr_pkg::ring_next(next_free_q) : next_free_q;
		latest_mid = hit0 ? first_q : latest_q;

		// slot 1 sees the ring after slot 0
		len1        = req.second_dma_address
			- (fbsr_pkg::buf_base(second_q, cfg) & fbsr_pkg::LEN_MASK);
		hit1        = req.second_pending && (len1 == expected);
		second_d    = hit1 ? next_mid : second_q;
		next_free_d = hit1 ? fbsr_pkg::ring_next(next_mid) : next_mid;
		latest_d    = hit1 ? second_q : latest_mid;

		res.first_reload       = req.first_pending;
		res.first_new_address  = req.first_pending ? fbsr_pkg::buf_base(first_d, cfg) : '0;
		res.first_stray        = req.first_pending
			&& ((req.first_dma_address < lo_bound) || (req.first_dma_address > hi_bound));
		res.second_reload      = req.second_pending;
		res.second_new_address = req.second_pending ? fbsr_pkg::buf_base(second_d, cfg) : '0;
		res.second_stray       = req.second_pending
			&& ((req.second_dma_address < lo_bound) || (req.second_dma_address > hi_bound));
		res.frame_done         = hit0 || hit1;
		res.shown_index        = 2'(latest_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= fbsr_pkg::RST_FIRST_SLOT;
			second_q    <= fbsr_pkg::RST_SECOND_SLOT;
			next_free_q <= fbsr_pkg::RST_NEXT_FREE;
			latest_q    <= fbsr_pkg::RST_LATEST;
		end else if (advance) begin
			first_q     <= first_d;
			second_q    <= second_d;
			next_free_q <= next_free_d;
			latest_q    <= latest_d;
		end
	end

	// ring pointer always names a real buffer
	`FBSR_ASSERT_NEVER(a_ring_in_range, clk, arst_n,
		(32'(next_free_q) >= 32'(fbsr_pkg::BUFFER_COUNT)))
	// an event without a finished frame leaves the ring alone
	`FBSR_ASSERT(a_ring_holds, clk, arst_n,
		(advance && !res.frame_done) |=> $stable(next_free_q) && $stable(latest_q))
	// no pending slot, no ownership change
	`FBSR_ASSERT(a_idle_slots_hold, clk, arst_n,
		(advance && !req.first_pending && !req.second_pending)
			|=> $stable(first_q) && $stable(second_q))

endmodule

[sim/tb_frame_buffer_slot_rotator.sv]
// Self-checking testbench for the frame buffer slot rotator: model, stimulus and result check.
module tb_frame_buffer_slot_rotator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	class slot_rotation_tracker;
		logic [11:0]      hres;
		logic [11:0]      vres;
		logic [27:0]      base;
		logic [23:0]      stride;
		fbsr_pkg::idx_t   first_slot;
		fbsr_pkg::idx_t   second_slot;
		fbsr_pkg::idx_t   next_free;
		fbsr_pkg::idx_t   latest;
		fbsr_pkg::out_t   awaited_reloads[$];
		int               failures;

		function new();
			hres        = fbsr_pkg::RST_HRES;
			vres        = fbsr_pkg::RST_VRES;
			base        = fbsr_pkg::RST_BASE;
			stride      = fbsr_pkg::RST_STRIDE;
			first_slot  = fbsr_pkg::RST_FIRST_SLOT;
			second_slot = fbsr_pkg::RST_SECOND_SLOT;
			next_free   = fbsr_pkg::RST_NEXT_FREE;
			latest      = fbsr_pkg::RST_LATEST;
			failures    = 0;
		endfunction

		function void set_reg(fbsr_pkg::cfg_idx_t idx, logic [27:0] value);
			case (idx)
				fbsr_pkg::REG_HRES:   hres = value[11:0];
				fbsr_pkg::REG_VRES:   vres = value[11:0];
				fbsr_pkg::REG_BASE:   base = value;
				fbsr_pkg::REG_STRIDE: stride = value[23:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] base_of(fbsr_pkg::idx_t idx);
			return 32'(base) + 32'(stride) * 32'(idx);
		endfunction

		function logic [31:0] frame_length();
			return 32'(hres) * 32'(vres) * 32'd2;
		endfunction

		function logic [31:0] region_lo();
			return 32'(base);
		endfunction

		// upper bound is inclusive
		function logic [31:0] region_hi();
			return 32'(base) + 32'(stride) * 32'(fbsr_pkg::BUFFER_COUNT);
		endfunction

		// address that completes a frame in the given slot right now
		function logic [31:0] frame_end(bit slot);
			fbsr_pkg::idx_t b;
			b = slot ? second_slot : first_slot;
			return (base_of(b) & fbsr_pkg::LEN_MASK) + frame_length();
		endfunction

		function void serve(input logic [31:0] addr, inout fbsr_pkg::idx_t slot,
				output logic [31:0] reload, inout bit done);
			logic [31:0] len;
			len = addr - (base_of(slot) & fbsr_pkg::LEN_MASK);
			if (len == frame_length()) begin
				latest = slot;
				slot = next_free;
				next_free = (int'(next_free) + 1 >= fbsr_pkg::BUFFER_COUNT) ? '0
					: fbsr_pkg::idx_t'(int'(next_free) + 1);
				done = 1'b1;
			end
			reload = base_of(slot);
		endfunction

		function void take_event(fbsr_pkg::in_t rq);
			fbsr_pkg::out_t r;
			bit             done;
			r = '0;
			done = 1'b0;
			r.first_reload  = rq.first_pending;
			r.second_reload = rq.second_pending;
			r.first_stray   = rq.first_pending &&
				(rq.first_dma_address < region_lo() || rq.first_dma_address > region_hi());
			r.second_stray  = rq.second_pending &&
				(rq.second_dma_address < region_lo() || rq.second_dma_address > region_hi());
			if (rq.first_pending)
				serve(rq.first_dma_address, first_slot, r.first_new_address, done);
			if (rq.second_pending)
				serve(rq.second_dma_address, second_slot, r.second_new_address, done);
			r.frame_done  = done;
			r.shown_index = 2'(latest);
			awaited_reloads.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
				failures++;
			end
		endfunction

		function void match_result(fbsr_pkg::out_t got);
			fbsr_pkg::out_t want;
			if (awaited_reloads.size() == 0) begin
				$display("%0t: result with nothing awaited, expected none actual %h", $time,
					got);
				failures++;
				return;
			end
			want = awaited_reloads.pop_front();
			compare_field("first_reload", 32'(want.first_reload), 32'(got.first_reload));
			compare_field("first_new_address", want.first_new_address, got.first_new_address);
			compare_field("first_stray", 32'(want.first_stray), 32'(got.first_stray));
			compare_field("second_reload", 32'(want.second_reload), 32'(got.second_reload));
			compare_field("second_new_address", want.second_new_address,
				got.second_new_address);
			compare_field("second_stray", 32'(want.second_stray), 32'(got.second_stray));
			compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
			compare_field("shown_index", 32'(want.shown_index), 32'(got.shown_index));
		endfunction

		function int outstanding();
			return awaited_reloads.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	fbsr_pkg::in_t                   in_data = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	fbsr_pkg::out_t                  out_data;
	logic                            cfg_wr_en = 1'b0;
	logic [fbsr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fbsr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	slot_rotation_tracker rotation = new();

	// set by the stimulus, picked up and counted out by the receiver
	bit hold_off_req = 1'b0;

	frame_buffer_slot_rotator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: the slowest legal run is far below this.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: checks every taken result, then picks the stall for the next cycle.
	// Stall pattern is a randomly redrawn mode; a long hold-off is served on request.
	initial begin
		int cyc;
		int mode;
		int hold_left;
		cyc = 0;
		mode = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				rotation.match_result(out_data);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 4) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (cyc % 4 == 0);
				endcase
			end
		end
	end

	// Offer one request and hold it until it is taken; the model follows at once,
	// so the next request can be built from the up-to-date slot state.
	task automatic send(fbsr_pkg::in_t rq);
		in_valid <= 1'b1;
		in_data  <= rq;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		rotation.take_event(rq);
	endtask

	// Wait for every awaited result, then let the two-stage pipe run dry.
	task automatic settle();
		in_valid <= 1'b0;
		while (rotation.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// enable is left high so writes can follow back to back
	task automatic write_reg(fbsr_pkg::cfg_idx_t idx, logic [27:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		rotation.set_reg(idx, value);
	endtask

	task automatic apply_settings(logic [11:0] h, logic [11:0] v, logic [27:0] b,
			logic [23:0] s);
		settle();
		write_reg(fbsr_pkg::REG_HRES, 28'(h));
		write_reg(fbsr_pkg::REG_VRES, 28'(v));
		write_reg(fbsr_pkg::REG_BASE, b);
		write_reg(fbsr_pkg::REG_STRIDE, 28'(s));
		cfg_wr_en <= 1'b0;
	endtask

	function automatic fbsr_pkg::in_t mk(logic p0, logic [31:0] a0, logic p1,
			logic [31:0] a1);
		fbsr_pkg::in_t rq;
		rq.first_pending      = p0;
		rq.first_dma_address  = a0;
		rq.second_pending     = p1;
		rq.second_dma_address = a1;
		return rq;
	endfunction

	// Half the addresses complete a frame, so the ring keeps turning.
	function automatic logic [31:0] pick_addr(bit slot);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return rotation.frame_end(slot);
		if (r < 60)
			return rotation.frame_end(slot) + ($urandom_range(0, 1) ? 32'd1 : 32'hffffffff);
		if (r < 75) begin
			case ($urandom_range(0, 3))
				0: return rotation.region_lo() - 32'd1;
				1: return rotation.region_lo();
				2: return rotation.region_hi();
				default: return rotation.region_hi() + 32'd1;
			endcase
		end
		return $urandom;
	endfunction

	function automatic fbsr_pkg::in_t random_item();
		logic        p0;
		logic        p1;
		logic [31:0] a0;
		logic [31:0] a1;
		p0 = ($urandom_range(0, 99) < 75);
		p1 = ($urandom_range(0, 99) < 75);
		a0 = pick_addr(1'b0);
		a1 = pick_addr(1'b1);
		return mk(p0, a0, p1, a1);
	endfunction

	// Corner events under the current settings.
	task automatic directed_items();
		// nothing pending, extreme addresses
		send(mk(1'b0, 32'h0, 1'b0, 32'hffffffff));
		// nothing pending although both addresses would complete: buffers stay put
		send(mk(1'b0, rotation.frame_end(1'b0), 1'b0, rotation.frame_end(1'b1)));
		// each slot completes alone, then both in one event
		send(mk(1'b1, rotation.frame_end(1'b0), 1'b0, 32'hffffffff));
		send(mk(1'b0, 32'h0, 1'b1, rotation.frame_end(1'b1)));
		send(mk(1'b1, rotation.frame_end(1'b0), 1'b1, rotation.frame_end(1'b1)));
		// one byte long and one byte short
		send(mk(1'b1, rotation.frame_end(1'b0) + 32'd1, 1'b1,
			rotation.frame_end(1'b1) - 32'd1));
		// only slot 1 completes
		send(mk(1'b1, rotation.frame_end(1'b0) ^ 32'h4, 1'b1, rotation.frame_end(1'b1)));
		// region bounds, upper one inclusive
		send(mk(1'b1, rotation.region_lo() - 32'd1, 1'b1, rotation.region_lo()));
		send(mk(1'b1, rotation.region_hi(), 1'b1, rotation.region_hi() + 32'd1));
		send(mk(1'b1, 32'h0, 1'b1, 32'hffffffff));
		send(mk(1'b1, 32'hffffffff, 1'b1, 32'h0));
	endtask

	// Bursts of random length with random gaps; some bursts run back to back.
	task automatic send_random(int n);
		int left;
		int burst;
		int gap;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && left > 0) begin
				send(random_item());
				burst--;
				left--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero frame length, default region
		directed_items();
		send_random(150);

		// typical 1080p layout; long receiver hold-off mid-phase
		apply_settings(12'd1920, 12'd1080, 28'h0200000, 24'd4147200);
		send_random(100);
		hold_off_req = 1'b1;
		repeat (30) send(random_item());
		// sender waits for the pipe to drain completely
		in_valid <= 1'b0;
		while (rotation.outstanding() != 0)
			@(posedge clk);
		send_random(70);

		// all registers at their top values
		apply_settings(12'hfff, 12'hfff, 28'hfffffff, 24'hffffff);
		directed_items();
		send_random(180);

		// all registers zero: every buffer shares one address
		apply_settings(12'd0, 12'd0, 28'h0, 24'h0);
		send_random(150);

		// tiny frames and stride
		apply_settings(12'd1, 12'd1, 28'($urandom), 24'd1);
		send_random(150);

		repeat (2) begin
			apply_settings(12'($urandom), 12'($urandom), 28'($urandom), 24'($urandom));
			send_random(175);
		end

		settle();
		repeat (10) @(posedge clk);
		if (rotation.outstanding() != 0) begin
			$display("%0t: results still awaited, expected 0 actual %0d", $time,
				rotation.outstanding());
			rotation.failures++;
		end
		if (rotation.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/fbsr_pkg.sv
rtl/fbsr_cfg_regs.sv
rtl/fbsr_slot_core.sv
rtl/frame_buffer_slot_rotator.sv
sim/tb_frame_buffer_slot_rotator.sv
